// File: hdl/bdsc_pkg.sv
// Shared types, constants and helpers for the bulk deframer with sum check.
// Used by bdsc_core, bdsc_outq, the top level and the port checker.
package bdsc_pkg;

    localparam int MAX_PAYLOAD  = 4096;
    localparam int HEADER_BYTES = 8;

    localparam int CAP_W  = 25;
    localparam int OFF_W  = 24;
    localparam int POS_W  = $clog2(MAX_PAYLOAD + HEADER_BYTES + 1);
    localparam int ROOM_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [CAP_W-1:0] CAP_LIMIT   = CAP_W'(1) << OFF_W;
    localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(4096);

    // configuration register indexes
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_CSUM_EN  = 1'b1;

    // header byte positions
    localparam logic [2:0] HDR_SEQ   = 3'd0;
    localparam logic [2:0] HDR_TOTAL = 3'd1;
    localparam logic [2:0] HDR_SUM   = 3'd3;
    localparam logic [2:0] HDR_SIZE0 = 3'd4;
    localparam logic [2:0] HDR_SIZE1 = 3'd5;
    localparam logic [2:0] HDR_SIZE2 = 3'd6;
    localparam logic [2:0] HDR_SIZE3 = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ABORT    = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SPACE = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_SEQ   = 3'd3;
    localparam logic [2:0] ST_LINK  = 3'd4;
    localparam logic [2:0] ST_SHORT = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [OFF_W-1:0] offset;
        logic [CAP_W-1:0] total;
        logic [2:0]       status;
        logic             last;
    } res_t;

    typedef res_t [1:0] res_pair_t;

    typedef struct packed {
        logic [1:0] count;
        res_pair_t  res;
    } push_t;

    function automatic res_t res_mk(
        input logic [1:0]       kind,
        input logic [7:0]       data,
        input logic [OFF_W-1:0] offset,
        input logic [CAP_W-1:0] total,
        input logic [2:0]       status
    );
        res_t r;
        r.kind   = kind;
        r.data   = data;
        r.offset = offset;
        r.total  = total;
        r.status = status;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

// File: hdl/bulk_deframer_with_sum_check.sv
// Top level of the bulk deframer with sum check: stream ports, config port.
// Depends on bdsc_pkg, bdsc_core and bdsc_outq.
//
//  channel   | direction | tdata                     | tuser      | tlast
//  ----------+-----------+---------------------------+------------+---------------
//  s_axis    | in        | rx_byte                   | link_fault | end_of_packet
//  m_axis    | out       | payload_byte, byte_offset,| kind       | last
//            |           | total_bytes, status       |            |
//  cfg       | in        | index 0 capacity, index 1 checksum_enable (write only)
//
// One request is taken per clock while s_axis_tready is high. Its results are
// decided in the accept cycle by bdsc_core and written into a four-entry result
// queue, from which they show on m_axis in order. A request yields up to two
// results, and the single output port moves one per cycle while m_axis_tready
// is high, so a stream of two-result requests fills the queue and is held back.
// s_axis_tready is high while the queue has room for two results; it does not
// depend on m_axis_tready in the same cycle.
// Reset is asynchronous and takes effect at once; no clearing pass follows.
module bulk_deframer_with_sum_check
    import bdsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // request stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
    input  logic             s_axis_tlast,   // end_of_packet
    input  logic [0:0]       s_axis_tuser,   // [0] link_fault
    // result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [7:0] payload_byte, [31:8] byte_offset,
                                             // [56:32] total_bytes, [59:57] status,
                                             // [63:60] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast,   // last result of its request
    // configuration writes
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CAP_W-1:0] cfg_wdata
);

    logic  accept;
    logic  has_room;
    push_t push;
    res_t  head;

    // accept a request only when both results it may cause fit in the queue
    assign s_axis_tready = has_room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bdsc_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .accept        (accept),
        .rx_byte       (s_axis_tdata),
        .end_of_packet (s_axis_tlast),
        .link_fault    (s_axis_tuser[0]),
        .push          (push)
    );

    bdsc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .has_room  (has_room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .head      (head)
    );

    // pack the result fields, lowest field first
    assign m_axis_tdata = {4'd0, head.status, head.total, head.offset, head.data};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

// File: hdl/bdsc_core.sv
// Deframer state and per-byte decision logic; up to two results per request.
// Depends on bdsc_pkg.
module bdsc_core
    import bdsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    input  logic             end_of_packet,
    input  logic             link_fault,
    output push_t            push
);

    // control state
    logic [CAP_W-1:0] capacity_reg, capacity_next;
    logic             csum_en_reg, csum_en_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [CAP_W-1:0] mo_reg, mo_next;
    logic             held_valid_reg, held_valid_next;
    logic             disc_reg, disc_next;
    logic             pend_valid_reg, pend_valid_next;
    // payload state
    logic [7:0]       seq_num_reg, seq_num_next;
    logic [7:0]       seq_tot_reg, seq_tot_next;
    logic [7:0]       exp_sum_reg, exp_sum_next;
    logic [31:0]      size_reg, size_next;
    logic [7:0]       held_byte_reg, held_byte_next;
    res_t             pend_reg, pend_next;

    logic [CAP_W-1:0]  cap_eff;
    logic [ROOM_W-1:0] room;
    logic [POS_W-1:0]  limit;

    res_pair_t        rs;
    logic [1:0]       k;
    logic [CAP_W-1:0] mo_v;
    logic [7:0]       sum_v;
    logic             ok;
    logic             fin;
    logic             fail;
    logic             done;
    res_t             term;

    function automatic res_pair_t put(input res_pair_t a, input logic [1:0] n, input res_t r);
        res_pair_t t;
        t = a;
        if (n != 2'd2)
        begin
            t[n[0]] = r;
        end
        return t;
    endfunction

    function automatic logic [1:0] bump(input logic [1:0] n);
        return (n == 2'd2) ? n : n + 2'd1;
    endfunction

    assign cap_eff = (capacity_reg > CAP_LIMIT) ? CAP_LIMIT : capacity_reg;
    assign room    = (cap_eff > CAP_W'(MAX_PAYLOAD)) ? ROOM_W'(MAX_PAYLOAD)
                                                      : cap_eff[ROOM_W-1:0];
    assign limit   = POS_W'(room) + POS_W'(HEADER_BYTES);

    always_comb
    begin
        capacity_next   = capacity_reg;
        csum_en_next    = csum_en_reg;
        pos_next        = pos_reg;
        held_valid_next = held_valid_reg;
        disc_next       = disc_reg;
        pend_valid_next = pend_valid_reg;
        seq_num_next    = seq_num_reg;
        seq_tot_next    = seq_tot_reg;
        exp_sum_next    = exp_sum_reg;
        size_next       = size_reg;
        held_byte_next  = held_byte_reg;
        pend_next       = pend_reg;
        rs    = '0;
        k     = 2'd0;
        mo_v  = mo_reg;
        sum_v = sum_reg;
        ok    = 1'b1;
        fin   = 1'b0;
        fail  = 1'b0;
        done  = 1'b0;
        term  = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAPACITY: capacity_next = cfg_wdata;
                REG_CSUM_EN:  csum_en_next  = cfg_wdata[0];
                default:      capacity_next = capacity_reg;
            endcase
        end

        if (accept)
        begin
            // a deferred terminal result goes out ahead of this byte's results
            if (pend_valid_reg)
            begin
                rs[0] = pend_reg;
                k     = 2'd1;
                pend_valid_next = 1'b0;
            end

            if (link_fault)
            begin
                rs = put(rs, k, res_mk(KIND_ABORT, 8'd0, '0, mo_v, ST_LINK));
                k  = bump(k);
                mo_v            = '0;
                held_valid_next = 1'b0;
                pos_next        = '0;
                sum_v           = 8'd0;
                disc_next       = 1'b0;
            end
            else if (disc_reg)
            begin
                if (end_of_packet)
                begin
                    disc_next = 1'b0;
                    pos_next  = '0;
                end
            end
            else if (pos_reg < POS_W'(HEADER_BYTES))
            begin
                case (pos_reg[2:0])
                    HDR_SEQ:
                    begin
                        seq_num_next    = rx_byte;
                        sum_v           = 8'd0;
                        held_valid_next = 1'b0;
                    end
                    HDR_TOTAL: seq_tot_next = rx_byte;
                    HDR_SUM:   exp_sum_next = rx_byte;
                    HDR_SIZE0: size_next    = {24'd0, rx_byte};
                    HDR_SIZE1: size_next[15:8]  = rx_byte;
                    HDR_SIZE2: size_next[23:16] = rx_byte;
                    HDR_SIZE3: size_next[31:24] = rx_byte;
                    default:   size_next = size_reg;
                endcase

                if (pos_reg == POS_W'(HEADER_BYTES - 1))
                begin
                    if (seq_num_reg > seq_tot_reg)
                    begin
                        rs = put(rs, k, res_mk(KIND_ABORT, 8'd0, '0, mo_v, ST_SEQ));
                        k  = bump(k);
                        mo_v            = '0;
                        held_valid_next = 1'b0;
                        disc_next       = !end_of_packet;
                        pos_next        = '0;
                    end
                    else if (end_of_packet)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        pos_next = POS_W'(HEADER_BYTES);
                    end
                end
                else if (end_of_packet)
                begin
                    rs = put(rs, k, res_mk(KIND_ABORT, 8'd0, '0, mo_v, ST_SHORT));
                    k  = bump(k);
                    mo_v            = '0;
                    held_valid_next = 1'b0;
                    pos_next        = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            else if (pos_reg >= limit)
            begin
                // receive buffer overflow
                rs = put(rs, k, res_mk(KIND_ABORT, 8'd0, '0, mo_v, ST_LINK));
                k  = bump(k);
                mo_v            = '0;
                held_valid_next = 1'b0;
                disc_next       = !end_of_packet;
                pos_next        = '0;
            end
            else if ({{(32-POS_W){1'b0}}, pos_reg} == size_reg)
            begin
                // one byte past the declared size: hold it until we know
                // whether it ends the packet
                if (end_of_packet)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    held_byte_next  = rx_byte;
                    held_valid_next = 1'b1;
                    pos_next        = pos_reg + POS_W'(1);
                end
            end
            else
            begin
                held_valid_next = 1'b0;
                if (held_valid_reg)
                begin
                    if (mo_v >= cap_eff)
                    begin
                        rs = put(rs, k, res_mk(KIND_ABORT, 8'd0, '0, mo_v, ST_SPACE));
                        k  = bump(k);
                        mo_v = '0;
                        ok   = 1'b0;
                    end
                    else
                    begin
                        rs = put(rs, k, res_mk(KIND_BYTE, held_byte_reg, mo_v[OFF_W-1:0],
                                               mo_v + CAP_W'(1), ST_OK));
                        k  = bump(k);
                        sum_v = sum_v + held_byte_reg;
                        mo_v  = mo_v + CAP_W'(1);
                    end
                end
                if (ok)
                begin
                    if (mo_v >= cap_eff)
                    begin
                        rs = put(rs, k, res_mk(KIND_ABORT, 8'd0, '0, mo_v, ST_SPACE));
                        k  = bump(k);
                        mo_v = '0;
                        ok   = 1'b0;
                    end
                    else
                    begin
                        rs = put(rs, k, res_mk(KIND_BYTE, rx_byte, mo_v[OFF_W-1:0],
                                               mo_v + CAP_W'(1), ST_OK));
                        k  = bump(k);
                        sum_v = sum_v + rx_byte;
                        mo_v  = mo_v + CAP_W'(1);
                    end
                end
                if (!ok)
                begin
                    disc_next = !end_of_packet;
                    pos_next  = '0;
                end
                else if (end_of_packet)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end

            // end of a packet with a complete header: checksum and sequence end
            if (fin)
            begin
                fail = csum_en_reg && (sum_v != exp_sum_reg);
                done = (seq_num_reg == seq_tot_reg);
                if (fail || done)
                begin
                    term = res_mk(fail ? KIND_ABORT : KIND_COMPLETE, 8'd0, '0, mo_v,
                                  fail ? ST_SUM : ST_OK);
                    if (k != 2'd2)
                    begin
                        rs = put(rs, k, term);
                        k  = bump(k);
                    end
                    else
                    begin
                        pend_valid_next = 1'b1;
                        pend_next       = term;
                    end
                    mo_v = '0;
                end
                pos_next        = '0;
                held_valid_next = 1'b0;
            end

            if (k == 2'd1)
            begin
                rs[0].last = 1'b1;
            end
            else if (k == 2'd2)
            begin
                rs[1].last = 1'b1;
            end
        end

        mo_next  = mo_v;
        sum_next = sum_v;
    end

    assign push.count = k;
    assign push.res   = rs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAP_RESET;
            csum_en_reg    <= 1'b1;
            pos_reg        <= '0;
            sum_reg        <= 8'd0;
            mo_reg         <= '0;
            held_valid_reg <= 1'b0;
            disc_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg   <= capacity_next;
            csum_en_reg    <= csum_en_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            mo_reg         <= mo_next;
            held_valid_reg <= held_valid_next;
            disc_reg       <= disc_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_num_reg   <= seq_num_next;
        seq_tot_reg   <= seq_tot_next;
        exp_sum_reg   <= exp_sum_next;
        size_reg      <= size_next;
        held_byte_reg <= held_byte_next;
        pend_reg      <= pend_next;
    end

endmodule

// File: hdl/bdsc_outq.sv
// Result queue: takes up to two a cycle, hands out one on out_ready.
// Depends on bdsc_pkg.
module bdsc_outq
    import bdsc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  has_room,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  head
);

    res_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = mem_reg[rd_reg];
    // room for the worst case of two results from one request
    assign has_room  = (cnt_reg <= (QPTR_W+1)'(QUEUE_DEPTH - 2));

    assign wr_next  = wr_reg + QPTR_W'(push.count);
    assign rd_next  = rd_reg + QPTR_W'(pop);
    assign cnt_next = cnt_reg + (QPTR_W+1)'(push.count) - (QPTR_W+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_reg] <= push.res[0];
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_reg + QPTR_W'(1)] <= push.res[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: hdl/bdsc_check.sv
// Port-level checker for the bulk deframer with sum check, bound to the top.
// Depends on bdsc_pkg.
module bdsc_check
    import bdsc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a delivered byte counts itself in the running total
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_BYTE |->
            m_axis_tdata[56:32] == {1'b0, m_axis_tdata[31:8]} + 25'd1
            && m_axis_tdata[59:57] == ST_OK)
        else $error("byte result has inconsistent total or status");

    // terminal results carry no byte and no offset
    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_COMPLETE || m_axis_tuser == KIND_ABORT) |->
            m_axis_tdata[31:0] == 32'd0)
        else $error("terminal result carries byte data");

    // a completion is never flagged with an error, an abort always is
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == KIND_COMPLETE && m_axis_tdata[59:57] == ST_OK)
            || (m_axis_tuser == KIND_ABORT && m_axis_tdata[59:57] != ST_OK
                && m_axis_tdata[59:57] <= ST_SHORT)
            || m_axis_tuser == KIND_BYTE)
        else $error("bad kind or status on result");

endmodule

bind bulk_deframer_with_sum_check bdsc_check u_check (.*);

// File: bench/bulk_deframer_with_sum_check_tb.sv
// Self-checking bench for bulk_deframer_with_sum_check: drives received packet
// bytes, predicts payload/complete/abort results and compares them in order.
// Depends on bdsc_pkg and the RTL of bulk_deframer_with_sum_check only.
module bulk_deframer_with_sum_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdsc_pkg::*;

    // Stop when nothing moves on either side for this many cycles.
    localparam int unsigned STALL_LIMIT  = 2000;
    // Cycles let pass once the last expected result is back, before the next
    // register write or the end of the run.
    localparam int unsigned DRAIN_CYCLES = 8;
    // Long output hold-off that fills the result queue and stalls the input.
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned PHASE_REQS   = 320;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       eop;
        logic       fault;
    } rx_req_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = '0;
    logic             s_axis_tlast = 1'b0;
    logic [0:0]       s_axis_tuser = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [63:0]      m_axis_tdata;
    logic [1:0]       m_axis_tuser;
    logic             m_axis_tlast;
    logic             cfg_we = 1'b0;
    logic             cfg_index = REG_CAPACITY;
    logic [CAP_W-1:0] cfg_wdata = '0;

    bulk_deframer_with_sum_check i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deframer prediction: own copy of the registers and the packet state
    // ------------------------------------------------------------------
    logic [CAP_W-1:0] cap_setting  = CAP_RESET;
    bit               sum_check_on = 1'b1;

    int unsigned pkt_pos;        // byte position inside the current packet
    logic [7:0]  seq_no;
    logic [7:0]  seq_last;
    logic [7:0]  hdr_sum;
    logic [31:0] size_field;
    logic [7:0]  pay_sum;        // additive sum of delivered payload bytes
    int unsigned msg_bytes;      // payload bytes delivered in this message
    logic [7:0]  held_data;
    bit          held_ok;
    bit          skipping;       // drop the rest of a failed packet
    bit          defer_ok;       // terminal result pushed to the next request
    logic [1:0]  defer_kind;
    logic [2:0]  defer_status;
    int unsigned defer_total;

    res_t step_results[$];       // results of the request being predicted
    res_t expected_results[$];   // results still owed by the block
    res_t want_res;

    function automatic int unsigned usable_capacity();
        return (cap_setting > CAP_LIMIT) ? int'(CAP_LIMIT) : int'(cap_setting);
    endfunction

    // At most two results per request; anything beyond is dropped.
    function automatic void emit(input logic [1:0] kind, input logic [7:0] data,
                                 input int unsigned offset, input int unsigned total,
                                 input logic [2:0] status);
        res_t r;
        r.kind   = kind;
        r.data   = data;
        r.offset = offset[OFF_W-1:0];
        r.total  = total[CAP_W-1:0];
        r.status = status;
        r.last   = 1'b0;
        if (step_results.size() < 2)
            step_results.push_back(r);
    endfunction

    function automatic void abort_message(input logic [2:0] status);
        emit(KIND_ABORT, 8'h00, 0, msg_bytes, status);
        msg_bytes = 0;
        held_ok   = 1'b0;
    endfunction

    function automatic bit deliver_byte(input logic [7:0] b);
        if (msg_bytes >= usable_capacity())
        begin
            abort_message(ST_SPACE);
            return 1'b0;
        end
        emit(KIND_BYTE, b, msg_bytes, msg_bytes + 1, ST_OK);
        pay_sum   = pay_sum + b;
        msg_bytes = msg_bytes + 1;
        return 1'b1;
    endfunction

    // Packet ended with a whole header: checksum first, then end of message.
    function automatic void close_packet();
        bit         term;
        logic [1:0] kind;
        logic [2:0] status;
        term   = 1'b0;
        kind   = KIND_COMPLETE;
        status = ST_OK;
        if (sum_check_on && pay_sum != hdr_sum)
        begin
            term   = 1'b1;
            kind   = KIND_ABORT;
            status = ST_SUM;
        end
        else if (seq_no == seq_last)
            term = 1'b1;
        if (term)
        begin
            if (step_results.size() < 2)
                emit(kind, 8'h00, 0, msg_bytes, status);
            else
            begin
                // both slots taken by the held byte and the final byte
                defer_ok     = 1'b1;
                defer_kind   = kind;
                defer_status = status;
                defer_total  = msg_bytes;
            end
            msg_bytes = 0;
        end
        pkt_pos = 0;
        held_ok = 1'b0;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic eop,
                                         input logic fault);
        int unsigned pos;
        int unsigned room;
        bit          ok;
        pos = pkt_pos;
        step_results.delete();
        if (defer_ok)
        begin
            emit(defer_kind, 8'h00, 0, defer_total, defer_status);
            defer_ok = 1'b0;
        end
        if (fault)
        begin
            abort_message(ST_LINK);
            pkt_pos  = 0;
            pay_sum  = '0;
            skipping = 1'b0;
        end
        else if (skipping)
        begin
            if (eop)
            begin
                skipping = 1'b0;
                pkt_pos  = 0;
            end
        end
        else if (pos < HEADER_BYTES)
        begin
            case (pos[2:0])
                HDR_SEQ:
                begin
                    seq_no  = b;
                    pay_sum = '0;
                    held_ok = 1'b0;
                end
                HDR_TOTAL: seq_last = b;
                HDR_SUM:   hdr_sum = b;
                HDR_SIZE0: size_field = {24'h0, b};
                HDR_SIZE1: size_field = size_field | {16'h0, b, 8'h0};
                HDR_SIZE2: size_field = size_field | {8'h0, b, 16'h0};
                HDR_SIZE3: size_field = size_field | {b, 24'h0};
                default: ;
            endcase
            if (pos == HEADER_BYTES - 1)
            begin
                if (seq_no > seq_last)
                begin
                    abort_message(ST_SEQ);
                    skipping = !eop;
                    pkt_pos  = 0;
                end
                else if (eop)
                    close_packet();
                else
                    pkt_pos = HEADER_BYTES;
            end
            else if (eop)
            begin
                abort_message(ST_SHORT);
                pkt_pos = 0;
            end
            else
                pkt_pos = pos + 1;
        end
        else
        begin
            room = usable_capacity();
            if (room > MAX_PAYLOAD)
                room = MAX_PAYLOAD;
            if (pos >= room + HEADER_BYTES)
            begin
                // receive buffer overflow reports as a link error
                abort_message(ST_LINK);
                skipping = !eop;
                pkt_pos  = 0;
            end
            else if (32'(pos) == size_field)
            begin
                // hold until the next byte tells whether this one is surplus
                if (eop)
                    close_packet();
                else
                begin
                    held_data = b;
                    held_ok   = 1'b1;
                    pkt_pos   = pos + 1;
                end
            end
            else
            begin
                ok = 1'b1;
                if (held_ok)
                begin
                    held_ok = 1'b0;
                    ok = deliver_byte(held_data);
                end
                if (ok)
                    ok = deliver_byte(b);
                if (!ok)
                begin
                    skipping = !eop;
                    pkt_pos  = 0;
                end
                else if (eop)
                    close_packet();
                else
                    pkt_pos = pos + 1;
            end
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            expected_results.push_back(step_results[i]);
    endfunction

    // ------------------------------------------------------------------
    // Request source: a queue of pending bytes and a clocked driver
    // ------------------------------------------------------------------
    rx_req_t     rx_requests[$];
    int unsigned reqs_queued = 0;
    bit          req_fire = 1'b0;
    bit          res_fire = 1'b0;
    int unsigned src_gap = 0;
    bit          src_burst = 1'b0;
    int unsigned sink_gap = 0;
    bit          sink_burst = 1'b0;
    int unsigned hold_left = 0;
    int unsigned next_hold_at = 150;
    int unsigned results_seen = 0;
    int unsigned fail_count = 0;
    int unsigned idle_cycles = 0;

    // Idle cycles before the next transfer; bursts of no idling come and go.
    function automatic int unsigned draw_wait(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 10);
    endfunction

    // Inputs change on the falling edge only.
    always @(negedge clk)
    begin : src_drive
        rx_req_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || req_fire)
        begin
            // keep offering during the output hold-off so the block fills up
            if (req_fire)
                src_gap = (hold_left > 0) ? 0 : draw_wait(src_burst);
            if (src_gap > 0)
            begin
                src_gap = src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (rx_requests.size() > 0)
            begin
                nxt = rx_requests.pop_front();
                s_axis_tdata  <= nxt.rx_byte;
                s_axis_tlast  <= nxt.eop;
                s_axis_tuser  <= nxt.fault;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result sink: random stall per result, plus the long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (results_seen >= next_hold_at)
        begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 2300;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (res_fire)
                sink_gap = draw_wait(sink_burst);
            if (sink_gap > 0)
            begin
                sink_gap = sink_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Rising edge: check the result leaving, predict for the request entering,
    // then run the watchdog. Checking first keeps the queue order exact.
    always @(posedge clk)
    begin
        req_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        res_fire <= rst_n && m_axis_tvalid && m_axis_tready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen = results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing outstanding: kind %0d, tdata %h",
                           m_axis_tuser, m_axis_tdata);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    if (m_axis_tuser !== want_res.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want_res.kind, m_axis_tuser);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[7:0] !== want_res.data)
                    begin
                        $error("payload_byte: expected %0h, got %0h",
                               want_res.data, m_axis_tdata[7:0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[31:8] !== want_res.offset)
                    begin
                        $error("byte_offset: expected %0d, got %0d",
                               want_res.offset, m_axis_tdata[31:8]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[56:32] !== want_res.total)
                    begin
                        $error("total_bytes: expected %0d, got %0d",
                               want_res.total, m_axis_tdata[56:32]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[59:57] !== want_res.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want_res.status, m_axis_tdata[59:57]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tlast !== want_res.last)
                    begin
                        $error("last: expected %0d, got %0d", want_res.last, m_axis_tlast);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[63:60] !== 4'h0)
                    begin
                        $error("tdata padding: expected 0, got %0h", m_axis_tdata[63:60]);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                deframe_byte(s_axis_tdata, s_axis_tlast, s_axis_tuser[0]);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else if (idle_cycles == STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                idle_cycles = idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building blocks
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b, input logic eop, input logic fault);
        rx_req_t r;
        r.rx_byte = b;
        r.eop     = eop;
        r.fault   = fault;
        rx_requests.push_back(r);
        reqs_queued = reqs_queued + 1;
    endtask

    // Eight header bytes; size goes little-endian.
    task automatic queue_header(input logic [7:0] seq, input logic [7:0] tot,
                                input logic [7:0] ptype, input logic [7:0] csum,
                                input logic [31:0] size, input logic eop_at_end);
        queue_byte(seq, 1'b0, 1'b0);
        queue_byte(tot, 1'b0, 1'b0);
        queue_byte(ptype, 1'b0, 1'b0);
        queue_byte(csum, 1'b0, 1'b0);
        queue_byte(size[7:0], 1'b0, 1'b0);
        queue_byte(size[15:8], 1'b0, 1'b0);
        queue_byte(size[23:16], 1'b0, 1'b0);
        queue_byte(size[31:24], eop_at_end, 1'b0);
    endtask

    // Whole packet with random payload. The size field either drops the
    // surplus last byte, lands inside the payload (held byte), or misses.
    task automatic send_packet(input logic [7:0] seq, input logic [7:0] tot,
                               input bit bad_sum, input int unsigned plen);
        logic [7:0]  body[$];
        logic [7:0]  csum;
        logic [31:0] size;
        int unsigned len;
        len = HEADER_BYTES + plen;
        for (int i = 0; i < plen; i++)
            body.push_back(8'($urandom_range(0, 255)));
        case ((plen == 0) ? 3 : $urandom_range(0, 3))
            0: size = len - 1;
            1: size = (plen >= 2) ? $urandom_range(HEADER_BYTES, len - 2) : len - 1;
            2: size = $urandom;
            default: size = len;
        endcase
        csum = '0;
        for (int i = 0; i < plen; i++)
            if (!(size == len - 1 && i == plen - 1))
                csum = csum + body[i];
        if (bad_sum)
            csum = csum + 8'($urandom_range(1, 255));
        queue_header(seq, tot, 8'($urandom_range(0, 255)), csum, size, plen == 0);
        for (int i = 0; i < plen; i++)
            queue_byte(body[i], i == plen - 1, 1'b0);
    endtask

    // Mostly well-formed messages; the rest short, faulted, out-of-order
    // or plain noise.
    task automatic queue_traffic();
        int unsigned pick;
        int unsigned base;
        int unsigned span;
        int unsigned n;
        int unsigned plen;
        logic [7:0]  tot;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            span = $urandom_range(0, 3);
            base = $urandom_range(0, 255 - span);
            for (int s = 0; s <= span; s++)
            begin
                plen = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(0, 12);
                send_packet(8'(base + s), 8'(base + span), $urandom_range(0, 9) == 0, plen);
            end
        end
        else if (pick < 78)
        begin
            n = $urandom_range(1, 7);
            for (int i = 0; i < n; i++)
                queue_byte(8'($urandom_range(0, 255)), i == n - 1, 1'b0);
        end
        else if (pick < 84)
            queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        else if (pick < 90)
        begin
            tot = 8'($urandom_range(0, 254));
            send_packet(8'($urandom_range(tot + 1, 255)), tot, 1'b0, $urandom_range(0, 8));
        end
        else if (pick < 95)
        begin
            // packet cut short by a failed transfer
            queue_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         $urandom, 1'b0);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                           $urandom_range(0, 7) == 0);
        end
    endtask

    // Hold until all requests are in and all results are back, then let the
    // pipeline settle before touching a register.
    task automatic wait_idle();
        while (rx_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CAP_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        if (idx == REG_CAPACITY)
            cap_setting = value;
        else
            sum_check_on = value[0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input bit csum_on);
        int unsigned start;
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_CSUM_EN, CAP_W'(csum_on));
        start = reqs_queued;
        while (reqs_queued - start < PHASE_REQS)
            queue_traffic();
        wait_idle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset settings (capacity 4096, checksum on).
        // Packet ending inside the header.
        queue_byte(8'h01, 1'b0, 1'b0);
        queue_byte(8'h02, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b1, 1'b0);
        // Single-packet message, size lands on the third payload byte: that
        // byte is held, then goes out with the final one, and the completion
        // is pushed to the next request.
        queue_header(8'h00, 8'h00, 8'hA5, 8'hFE, 32'd10, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h80, 1'b0, 1'b0);
        queue_byte(8'h7F, 1'b1, 1'b0);
        // Link fault: deferred completion first, then the link abort.
        queue_byte(8'h5A, 1'b0, 1'b1);
        // Header-only packet with sequence above total.
        queue_header(8'hFF, 8'h00, 8'h00, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        wait_idle();

        // Random part across register settings, extremes included.
        run_phase(25'd24, 1'b1);
        run_phase(25'd1, 1'b1);
        run_phase(25'd300, 1'b0);
        run_phase(CAP_LIMIT, 1'b1);
        run_phase({CAP_W{1'b1}}, 1'b0);
        run_phase(CAP_RESET, 1'b1);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/bdsc_pkg.sv
hdl/bdsc_core.sv
hdl/bdsc_outq.sv
hdl/bulk_deframer_with_sum_check.sv
hdl/bdsc_check.sv
bench/bulk_deframer_with_sum_check_tb.sv
